[rtl/gif_pkg.sv]
`timescale 1ns / 1ps
package gif_pkg;
	localparam int DICT_ENTRIES  = 4096;
	localparam int MAX_CODE_BITS = 12;
	localparam int STACK_DEPTH   = 4096;
	localparam int CODE_W  = $clog2(DICT_ENTRIES);
	localparam int STACK_W = $clog2(STACK_DEPTH);

	localparam logic [1:0] REQ_PUSH    = 2'd0;
	localparam logic [1:0] REQ_PULL    = 2'd1;
	localparam logic [1:0] REQ_RESTART = 2'd2;

	localparam logic [1:0] ADDR_MIN_CODE_BITS = 2'd0;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic push_byte;
		logic restart;
		logic take_code;
		logic walk_start;
		logic walk_step;
		logic walk_finish;
		logic pop;
		logic end_of_data;
	} gif_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic done;
		logic final_seen;
		logic stack_empty;
		logic buf_room;
		logic code_ready;
		logic code_needs_walk;
		logic walk_last;
	} gif_sts_t;
endpackage

[rtl/gif_ctrl.sv]
`timescale 1ns / 1ps
module gif_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        req_type,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              byte_taken,
	output logic              pixel_valid,
	output logic              last_pixel,
	output logic              finished,
	output logic              pix_sel,
	output gif_pkg::gif_cmd_t cmd,
	input  gif_pkg::gif_sts_t sts
);
	import gif_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_FILL = 5'b00010,
		S_WALK = 5'b00100,
		S_POST = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   popped_q, popped_d;
	logic   taken_q, taken_d;
	logic   last_q, last_d;

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = (state_q == S_OUT);
	assign byte_taken  = taken_q;
	assign pixel_valid = popped_q;
	assign last_pixel  = last_q;
	assign finished    = sts.done;
	assign pix_sel     = popped_q;

	always_comb begin
		state_d  = state_q;
		popped_d = popped_q;
		taken_d  = taken_q;
		last_d   = last_q;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					popped_d = 1'b0;
					taken_d  = 1'b0;
					last_d   = 1'b0;
					priority case (req_type)
						REQ_PUSH: begin
							if (sts.done || sts.final_seen) begin
								taken_d = 1'b1;
							end else if (sts.buf_room) begin
								cmd.push_byte = 1'b1;
								taken_d = 1'b1;
							end
							state_d = S_OUT;
						end
						REQ_PULL: state_d = S_FILL;
						REQ_RESTART: begin
							cmd.restart = 1'b1;
							state_d = S_OUT;
						end
						default: state_d = S_OUT;
					endcase
				end
			end
			S_FILL, S_POST: begin
				// Decode codes while the stack is empty and nothing ends the image.
				if (sts.stack_empty && !sts.done) begin
					if (sts.code_ready) begin
						cmd.take_code = 1'b1;
						if (sts.code_needs_walk) begin
							cmd.walk_start = 1'b1;
							state_d = S_WALK;
						end
					end else begin
						if (sts.final_seen) cmd.end_of_data = 1'b1;
						if (state_q == S_FILL) state_d = S_OUT;
					end
				end else if (state_q == S_FILL && !sts.stack_empty) begin
					cmd.pop  = 1'b1;
					popped_d = 1'b1;
					state_d  = S_POST;
				end else begin
					state_d = S_OUT;
				end
				if (state_q == S_POST && state_d == S_OUT) last_d = sts.stack_empty && sts.done;
				if (state_q == S_POST && state_d == S_POST && !cmd.take_code) begin
					last_d  = sts.stack_empty && (sts.done || sts.final_seen);
					state_d = S_OUT;
				end
			end
			S_WALK: begin
				if (sts.walk_last) begin
					cmd.walk_finish = 1'b1;
					state_d = popped_q ? S_POST : S_FILL;
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			S_OUT: begin
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			popped_q <= 1'b0;
			taken_q  <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			popped_q <= popped_d;
			taken_q  <= taken_d;
			last_q   <= last_d;
		end
	end
endmodule

[rtl/gif_datapath.sv]
`timescale 1ns / 1ps
module gif_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [3:0]        min_code_bits,
	input  logic [7:0]        data_byte,
	input  logic              final_byte,
	input  logic              pix_sel,
	output logic [7:0]        pixel_index,
	input  gif_pkg::gif_cmd_t cmd,
	output gif_pkg::gif_sts_t sts
);
	import gif_pkg::*;

	logic [CODE_W-1:0]  prefix_mem [DICT_ENTRIES];
	logic [7:0]         suffix_mem [DICT_ENTRIES];
	logic [7:0]         stack_mem  [STACK_DEPTH];

	logic [STACK_W:0]   stack_cnt_q;
	logic [31:0]        buf_q;
	logic [5:0]         bit_cnt_q;
	logic [3:0]         width_q;
	logic [CODE_W:0]    next_q;
	logic [CODE_W-1:0]  prev_q;
	logic [7:0]         first_q;
	logic               have_prev_q;
	logic               done_q;
	logic [3:0]         base_q;
	logic               final_q;
	logic [CODE_W-1:0]  walk_q;
	logic [CODE_W-1:0]  code_q;
	logic [7:0]         pix_q;
	logic [CODE_W-1:0]  pre_rd_q;
	logic [7:0]         suf_rd_q;

	logic [CODE_W:0]    clear_c;
	logic [CODE_W-1:0]  code_c;
	logic               is_lit;
	logic [CODE_W:0]    code_x;
	logic               walk_more;
	logic [3:0]         base_c;
	logic [CODE_W-1:0]  walk_d;

	assign clear_c = (CODE_W+1)'(1) << base_q;
	assign code_c  = CODE_W'(buf_q & ((32'd1 << width_q) - 32'd1));
	assign code_x  = {1'b0, code_c};
	assign walk_more = ({1'b0, walk_q} >= clear_c + (CODE_W+1)'(2));
	assign is_lit = 1'b0;
	assign base_c = (min_code_bits < 4'd2) ? 4'd2 : (min_code_bits > 4'd8) ? 4'd8
		: min_code_bits;

	// Once a code is held, each data code up to next_q needs the walk.
	assign sts.code_needs_walk = have_prev_q && (code_x != clear_c)
		&& (code_x != clear_c + 1'b1) && (code_x <= next_q);
	assign sts.done        = done_q;
	assign sts.final_seen  = final_q;
	assign sts.stack_empty = (stack_cnt_q == '0) || is_lit;
	assign sts.buf_room    = (bit_cnt_q <= 6'd24);
	assign sts.code_ready  = (bit_cnt_q >= {2'b00, width_q});
	assign sts.walk_last   = !walk_more;

	assign pixel_index = pix_sel ? pix_q : 8'd0;

	logic              spush;
	logic [7:0]        sval;
	logic              dict_wr;
	logic [7:0]        root_c;

	assign root_c = walk_q[7:0];

	// The dictionary is read at the next walk address, so the entry of the
	// current walk position is always waiting in the read registers.
	always_comb begin
		walk_d = walk_q;
		if (cmd.take_code && cmd.walk_start)
			walk_d = (code_x == next_q) ? prev_q : code_c;
		else if (cmd.walk_step)
			walk_d = pre_rd_q;
	end

	always_comb begin
		spush = 1'b0;
		sval  = 8'd0;
		if (cmd.take_code && !cmd.walk_start && have_prev_q == 1'b0
				&& code_x < clear_c) begin
			spush = 1'b1;
			sval  = code_c[7:0];
		end else if (cmd.take_code && cmd.walk_start && code_x == next_q) begin
			spush = 1'b1;
			sval  = first_q;
		end else if (cmd.walk_step) begin
			spush = 1'b1;
			sval  = suf_rd_q;
		end else if (cmd.walk_finish) begin
			spush = 1'b1;
			sval  = root_c;
		end
	end
	assign dict_wr = cmd.walk_finish && (next_q < (CODE_W+1)'(DICT_ENTRIES));

	always_ff @(posedge clk) begin
		if (spush && stack_cnt_q < (STACK_W+1)'(STACK_DEPTH))
			stack_mem[stack_cnt_q[STACK_W-1:0]] <= sval;
		if (dict_wr) begin
			prefix_mem[next_q[CODE_W-1:0]] <= prev_q;
			suffix_mem[next_q[CODE_W-1:0]] <= root_c;
		end
		pre_rd_q <= prefix_mem[walk_d];
		suf_rd_q <= suffix_mem[walk_d];
		if (cmd.pop) pix_q <= stack_mem[stack_cnt_q[STACK_W-1:0] - 1'b1];
		if (cmd.walk_start) code_q <= code_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_cnt_q <= '0;
			buf_q       <= '0;
			bit_cnt_q   <= '0;
			width_q     <= 4'd9;
			next_q      <= (CODE_W+1)'(258);
			prev_q      <= '0;
			first_q     <= '0;
			have_prev_q <= 1'b0;
			done_q      <= 1'b0;
			base_q      <= 4'd8;
			final_q     <= 1'b0;
			walk_q      <= '0;
		end else begin
			walk_q <= walk_d;
			if (spush && stack_cnt_q < (STACK_W+1)'(STACK_DEPTH))
				stack_cnt_q <= stack_cnt_q + 1'b1;
			if (cmd.pop) stack_cnt_q <= stack_cnt_q - 1'b1;
			if (cmd.restart) begin
				base_q      <= base_c;
				stack_cnt_q <= '0;
				buf_q       <= '0;
				bit_cnt_q   <= '0;
				width_q     <= base_c + 4'd1;
				next_q      <= ((CODE_W+1)'(1) << base_c) + (CODE_W+1)'(2);
				prev_q      <= '0;
				first_q     <= '0;
				have_prev_q <= 1'b0;
				done_q      <= 1'b0;
				final_q     <= 1'b0;
			end
			if (cmd.push_byte) begin
				buf_q     <= buf_q | (32'(data_byte) << bit_cnt_q);
				bit_cnt_q <= bit_cnt_q + 6'd8;
				if (final_byte) final_q <= 1'b1;
			end
			if (cmd.end_of_data) begin
				done_q    <= 1'b1;
				buf_q     <= '0;
				bit_cnt_q <= '0;
			end
			if (cmd.take_code) begin
				buf_q     <= buf_q >> width_q;
				bit_cnt_q <= bit_cnt_q - {2'b00, width_q};
				if (code_x == clear_c) begin
					width_q     <= base_q + 4'd1;
					next_q      <= clear_c + (CODE_W+1)'(2);
					have_prev_q <= 1'b0;
				end else if (code_x == clear_c + 1'b1) begin
					done_q <= 1'b1;
				end else if (!have_prev_q) begin
					if (code_x < clear_c) begin
						prev_q      <= code_c;
						first_q     <= code_c[7:0];
						have_prev_q <= 1'b1;
					end else begin
						done_q <= 1'b1;
					end
				end else if (code_x > next_q) begin
					done_q <= 1'b1;
				end
			end
			if (cmd.walk_finish) begin
				if (dict_wr) begin
					next_q <= next_q + 1'b1;
					if ((next_q + 1'b1) == ((CODE_W+1)'(1) << width_q)
							&& width_q < 4'(MAX_CODE_BITS))
						width_q <= width_q + 4'd1;
				end
				prev_q  <= code_q;
				first_q <= root_c;
			end
		end
	end
endmodule

[rtl/gif_lzw_decoder_top.sv]
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// request   in_valid/in_ready     req_type, data_byte, final_byte
// result    out_valid/out_ready   byte_taken, pixel_valid, pixel_index, last_pixel, finished
// config    APB psel/penable      min_code_bits at address 0
// A push, restart or no-op offers its result in the cycle after it is accepted.
// A pull decodes codes in S_FILL until the stack holds a pixel, pops it and then
// decodes ahead in S_POST; a dictionary string is walked in S_WALK, one symbol per cycle.
// arst_n clears all control state; dictionary and stack are not cleared.
// One item is in flight at a time; the result waits in place for out_ready.
module gif_lzw_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [7:0]  data_byte,
	input  logic        final_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        byte_taken,
	output logic        pixel_valid,
	output logic [7:0]  pixel_index,
	output logic        last_pixel,
	output logic        finished
);
	import gif_pkg::*;

	logic [3:0] min_bits_q;
	gif_cmd_t   cmd;
	gif_sts_t   sts;
	logic       pix_sel;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_MIN_CODE_BITS) ? {28'd0, min_bits_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_bits_q <= 4'd8;
		end else if (psel && penable && pwrite && paddr == ADDR_MIN_CODE_BITS) begin
			min_bits_q <= pwdata[3:0];
		end
	end

	gif_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .req_type, .out_valid, .out_ready,
		.byte_taken, .pixel_valid, .last_pixel, .finished, .pix_sel, .cmd, .sts
	);

	gif_datapath u_dp (
		.clk, .arst_n, .min_code_bits(min_bits_q), .data_byte, .final_byte,
		.pix_sel, .pixel_index, .cmd, .sts
	);
endmodule
